/* hdl/pist_pkg.sv */
// ----------------------------------------------------------------------------
// pist_pkg
// Shared constants for the per-id state interval tracker: field widths,
// configuration register indexes, register reset values and state codes.
// ----------------------------------------------------------------------------
package pist_pkg;

  // Payload field widths
  localparam int ID_W       = 16;
  localparam int STATE_W    = 8;
  localparam int FRAME_W    = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_USE_ALL_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LAST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 2'd3;

  // Register reset values
  localparam logic RST_USE_ALL_FRAMES = 1'b1;
  localparam int   RST_WINDOW_FIRST   = 0;
  localparam int   RST_WINDOW_LAST    = 1;
  localparam int   RST_FRAME_COUNT    = 1;

  // Sample state codes that cause transitions
  localparam logic [STATE_W-1:0] STATE_LOW  = 8'd0;
  localparam logic [STATE_W-1:0] STATE_HIGH = 8'd1;

endpackage

/* hdl/per_id_state_interval_tracker_top.sv */
// ----------------------------------------------------------------------------
// per_id_state_interval_tracker_top
// Tracks a per-id seen/state/frame entry in a RAM and emits an interval
// transaction each time an id's state falls from 1 back to 0 within the window.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------
//   sample   | sample_valid/sample_ready  | particle_id, particle_state,
//            |                            | frame_number
//   event    | event_valid/event_ready    | event_id, start_frame, end_frame
//   config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// One sample per cycle while no held event stalls the update stage: the RAM
// read is issued at acceptance, the entry is updated in the update stage and
// written back when that stage completes, and a one-deep bypass covers
// back-to-back samples of the same id. An event enters the output register
// when its sample completes the update stage. After reset a clearing pass
// writes all 2**ID_BITS entries, one per cycle, with sample_ready held low.
// A held event with event_ready low stalls a second emitting sample in the
// update stage, which holds sample_ready low.
// ----------------------------------------------------------------------------
module per_id_state_interval_tracker_top #(
  parameter int ID_BITS    = 16,
  parameter int FRAME_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pist_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pist_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  logic [pist_pkg::ID_W-1:0]        particle_id,
  input  logic [pist_pkg::STATE_W-1:0]     particle_state,
  input  logic [pist_pkg::FRAME_W-1:0]     frame_number,
  output logic                             event_valid,
  input  logic                             event_ready,
  output logic [pist_pkg::ID_W-1:0]        event_id,
  output logic [pist_pkg::FRAME_W-1:0]     start_frame,
  output logic [pist_pkg::FRAME_W-1:0]     end_frame
);

  localparam int CW = FRAME_BITS + 1;
  localparam int DW = FRAME_BITS + 2;

  // Window bounds
  logic [CW-1:0] win_lo, win_hi;
  logic          win_empty;

  // Clearing pass
  logic               clearing;
  logic [ID_BITS-1:0] clr_addr;

  // Update stage
  logic                        s1_valid;
  logic [pist_pkg::ID_W-1:0]   s1_id;
  logic                        s1_in_range;
  logic                        s1_st_low, s1_st_high;
  logic [FRAME_BITS-1:0]       s1_frame;

  // Bypass of the last item write
  logic               fwd_valid;
  logic [ID_BITS-1:0] fwd_addr;
  logic [DW-1:0]      fwd_data;

  logic                    sample_accept;
  logic [ID_BITS+15:0]     id_wide, s1_id_wide;
  logic [FRAME_BITS+15:0]  fr_wide;
  logic [ID_BITS-1:0]      s1_addr;
  logic [DW-1:0]           rdata, ent;
  logic                    ent_seen, ent_state;
  logic [FRAME_BITS-1:0]   ent_frame;
  logic                    in_window;
  logic                    do_write, emit;
  logic [DW-1:0]           new_entry;
  logic                    s1_done, s1_fire;
  logic                    mem_we;
  logic [ID_BITS-1:0]      mem_waddr;
  logic [DW-1:0]           mem_wdata;
  logic [FRAME_BITS+15:0]  sf_wide, ef_wide;

  pist_window #(
    .FRAME_BITS(FRAME_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .win_lo   (win_lo),
    .win_hi   (win_hi),
    .win_empty(win_empty)
  );

  assign id_wide       = {{ID_BITS{1'b0}}, particle_id};
  assign fr_wide       = {{FRAME_BITS{1'b0}}, frame_number};
  assign sample_accept = sample_valid && sample_ready;

  pist_table #(
    .ADDR_BITS(ID_BITS),
    .DATA_BITS(DW)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (sample_accept),
    .raddr(id_wide[ID_BITS-1:0]),
    .rdata(rdata)
  );

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ID_BITS'(1);
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // Update stage payload
  always_ff @(posedge clk) begin
    if (sample_accept) begin
      s1_id       <= particle_id;
      s1_in_range <= (id_wide[ID_BITS+15:ID_BITS] == '0);
      s1_st_low   <= (particle_state == pist_pkg::STATE_LOW);
      s1_st_high  <= (particle_state == pist_pkg::STATE_HIGH);
      s1_frame    <= fr_wide[FRAME_BITS-1:0];
    end
  end

  assign s1_id_wide = {{ID_BITS{1'b0}}, s1_id};
  assign s1_addr    = s1_id_wide[ID_BITS-1:0];

  // Take the bypass when the RAM read collided with the previous write
  assign ent       = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rdata;
  assign ent_seen  = ent[DW-1];
  assign ent_state = ent[FRAME_BITS];
  assign ent_frame = ent[FRAME_BITS-1:0];

  assign in_window = s1_in_range && !win_empty &&
                     ({1'b0, s1_frame} >= win_lo) && ({1'b0, s1_frame} <= win_hi);

  always_comb begin
    do_write  = 1'b0;
    emit      = 1'b0;
    new_entry = {1'b1, 1'b0, s1_frame};
    if (in_window) begin
      if (!ent_seen) begin
        do_write = s1_st_low;
      end else if (!ent_state && s1_st_high) begin
        do_write  = 1'b1;
        new_entry = {1'b1, 1'b1, s1_frame};
      end else if (ent_state && s1_st_low) begin
        do_write = 1'b1;
        emit     = 1'b1;
      end
    end
  end

  assign s1_done      = !emit || !event_valid || event_ready;
  assign s1_fire      = s1_valid && s1_done;
  assign sample_ready = !clearing && (!s1_valid || s1_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  assign mem_we    = clearing || (s1_fire && do_write);
  assign mem_waddr = clearing ? clr_addr : s1_addr;
  assign mem_wdata = clearing ? '0 : new_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_fire && do_write) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && do_write) begin
      fwd_addr <= s1_addr;
      fwd_data <= new_entry;
    end
  end

  // Output register
  assign sf_wide = {16'b0, ent_frame};
  assign ef_wide = {16'b0, s1_frame};

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      event_id    <= s1_id;
      start_frame <= sf_wide[15:0];
      end_frame   <= ef_wide[15:0];
    end
  end

  // Assertions
  a_no_item_write_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !s1_fire)
    else $error("item update during clearing pass");

  a_event_from_update: assert property (
    @(posedge clk) disable iff (rst) (event_valid && !$past(event_valid)) |-> $past(s1_fire))
    else $error("event appeared without a completing update");

  a_no_bypass_after_clear: assert property (
    @(posedge clk) disable iff (rst) $fell(clearing) |-> !fwd_valid)
    else $error("bypass holds data across the clearing pass");

  a_emit_in_window: assert property (
    @(posedge clk) disable iff (rst) (s1_fire && emit) |-> (!win_empty && s1_in_range))
    else $error("event from a sample outside the window");

endmodule

/* hdl/pist_table.sv */
// ----------------------------------------------------------------------------
// pist_table
// Single-port-write, single-port-read synchronous RAM holding one entry per
// id. Read data is registered and holds when no read is issued.
// ----------------------------------------------------------------------------
module pist_table #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 18
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read before write on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/pist_window.sv */
// ----------------------------------------------------------------------------
// pist_window
// Configuration registers and frame window bounds. The bounds are
// recomputed from the registers every cycle and registered.
// ----------------------------------------------------------------------------
module pist_window #(
  parameter int FRAME_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pist_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pist_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [FRAME_BITS:0]            win_lo,
  output logic [FRAME_BITS:0]            win_hi,
  output logic                           win_empty
);

  localparam int CW = FRAME_BITS + 1;

  logic                  use_all_frames;
  logic [FRAME_BITS-1:0] window_first;
  logic [FRAME_BITS-1:0] window_last;
  logic [CW-1:0]         num_frames;

  logic [FRAME_BITS+15:0] data_frame_wide;
  logic [FRAME_BITS+16:0] data_count_wide;

  logic [CW-1:0] a_ext, b_ext, a_ord, b_ord;
  logic [CW-1:0] lo_next, hi_next;

  // Mask write data down to the register widths
  assign data_frame_wide = {{FRAME_BITS{1'b0}}, cfg_data[15:0]};
  assign data_count_wide = {{FRAME_BITS{1'b0}}, cfg_data[16:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      use_all_frames <= pist_pkg::RST_USE_ALL_FRAMES;
      window_first   <= FRAME_BITS'(pist_pkg::RST_WINDOW_FIRST);
      window_last    <= FRAME_BITS'(pist_pkg::RST_WINDOW_LAST);
      num_frames     <= CW'(pist_pkg::RST_FRAME_COUNT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pist_pkg::REG_USE_ALL_FRAMES: use_all_frames <= cfg_data[0];
        pist_pkg::REG_WINDOW_FIRST:   window_first   <= data_frame_wide[FRAME_BITS-1:0];
        pist_pkg::REG_WINDOW_LAST:    window_last    <= data_frame_wide[FRAME_BITS-1:0];
        pist_pkg::REG_FRAME_COUNT:    num_frames     <= data_count_wide[CW-1:0];
        default: ;
      endcase
    end
  end

  assign a_ext = {1'b0, window_first};
  assign b_ext = {1'b0, window_last};
  assign a_ord = (a_ext > b_ext) ? b_ext : a_ext;
  assign b_ord = (a_ext > b_ext) ? a_ext : b_ext;

  always_comb begin
    if (use_all_frames) begin
      // Zero frame count wraps to all ones: every frame passes
      lo_next = '0;
      hi_next = num_frames - CW'(1);
    end else if (num_frames < CW'(2)) begin
      lo_next = '0;
      hi_next = '0;
    end else if (num_frames == CW'(2)) begin
      lo_next = '0;
      hi_next = CW'(1);
    end else begin
      lo_next = (a_ord >= num_frames) ? num_frames - CW'(2) : a_ord;
      hi_next = (b_ord >= num_frames) ? num_frames - CW'(1) : b_ord;
    end
  end

  always_ff @(posedge clk) begin
    win_lo    <= lo_next;
    win_hi    <= hi_next;
    win_empty <= (lo_next == '0) && (hi_next == '0);
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-id state interval tracker. A shadow copy of
// the id table and window registers predicts each interval from the accepted
// samples. Every event transaction is compared field by field against the
// oldest predicted interval. Directed tests cover window corner cases and each
// transition, then random phases run short per-id state streams under
// random backpressure on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int ID_W       = pist_pkg::ID_W;
  localparam int STATE_W    = pist_pkg::STATE_W;
  localparam int FRAME_W    = pist_pkg::FRAME_W;
  localparam int CNT_W      = pist_pkg::FRAME_W + 1;
  localparam int CFG_IDX_W  = pist_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pist_pkg::CFG_DATA_W;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [FRAME_W-1:0] rise_frame;
    logic [FRAME_W-1:0] fall_frame;
  } interval_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = pist_pkg::REG_USE_ALL_FRAMES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  logic [ID_W-1:0]       particle_id = '0;
  logic [STATE_W-1:0]    particle_state = '0;
  logic [FRAME_W-1:0]    frame_number = '0;
  logic                  event_valid;
  logic                  event_ready = 1'b0;
  logic [ID_W-1:0]       event_id;
  logic [FRAME_W-1:0]    start_frame;
  logic [FRAME_W-1:0]    end_frame;

  // shadow of the configuration registers
  logic                  all_frames_r = pist_pkg::RST_USE_ALL_FRAMES;
  logic [FRAME_W-1:0]    first_r = FRAME_W'(pist_pkg::RST_WINDOW_FIRST);
  logic [FRAME_W-1:0]    last_r = FRAME_W'(pist_pkg::RST_WINDOW_LAST);
  logic [FRAME_W:0]      num_frames_r = CNT_W'(pist_pkg::RST_FRAME_COUNT);

  // shadow of the id table
  bit                    id_seen [1 << ID_W];
  bit                    id_level [1 << ID_W];
  logic [FRAME_W-1:0]    id_frame [1 << ID_W];

  interval_t             pending_intervals[$];
  interval_t             want;
  int                    fail_count = 0;
  int                    recv_wait = 0;
  bit                    sender_fast = 1'b0;
  bit                    receiver_fast = 1'b0;

  per_id_state_interval_tracker_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .particle_id   (particle_id),
    .particle_state(particle_state),
    .frame_number  (frame_number),
    .event_valid   (event_valid),
    .event_ready   (event_ready),
    .event_id      (event_id),
    .start_frame   (start_frame),
    .end_frame     (end_frame)
  );

  always #4 clk = ~clk;

  // Window bounds from the current register values; hi is one bit wider so
  // that a zero frame count with all frames wraps to all ones.
  function automatic void window_of(output logic [FRAME_W:0] lo,
                                    output logic [FRAME_W:0] hi);
    logic [FRAME_W:0] a, b, t;
    if (all_frames_r) begin
      lo = '0;
      hi = num_frames_r - CNT_W'(1);
      return;
    end
    if (num_frames_r < CNT_W'(2)) begin
      lo = '0;
      hi = '0;
    end else if (num_frames_r == CNT_W'(2)) begin
      lo = '0;
      hi = CNT_W'(1);
    end else begin
      a = {1'b0, first_r};
      b = {1'b0, last_r};
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      if (a >= num_frames_r) a = num_frames_r - CNT_W'(2);
      if (b >= num_frames_r) b = num_frames_r - CNT_W'(1);
      lo = a;
      hi = b;
    end
  endfunction

  // Apply one sample to the shadow table; returns 1 when it closes an interval.
  function automatic bit track_sample(input logic [ID_W-1:0] id,
                                      input logic [STATE_W-1:0] st,
                                      input logic [FRAME_W-1:0] fr,
                                      output interval_t ev);
    logic [FRAME_W:0] lo, hi;
    window_of(lo, hi);
    if (lo == 0 && hi == 0) return 1'b0;
    if ({1'b0, fr} < lo || {1'b0, fr} > hi) return 1'b0;
    if (!id_seen[id]) begin
      if (st == pist_pkg::STATE_LOW) begin
        id_seen[id] = 1'b1;
        id_level[id] = 1'b0;
        id_frame[id] = fr;
      end
      return 1'b0;
    end
    if (!id_level[id] && st == pist_pkg::STATE_HIGH) begin
      id_level[id] = 1'b1;
      id_frame[id] = fr;
      return 1'b0;
    end
    if (id_level[id] && st == pist_pkg::STATE_LOW) begin
      ev = '{id: id, rise_frame: id_frame[id], fall_frame: fr};
      id_level[id] = 1'b0;
      id_frame[id] = fr;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back samples need no extra edge.
  task automatic send_sample(input logic [ID_W-1:0] id,
                             input logic [STATE_W-1:0] st,
                             input logic [FRAME_W-1:0] fr);
    int gap;
    interval_t ev;
    gap = sender_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid   <= 1'b1;
    particle_id    <= id;
    particle_state <= st;
    frame_number   <= fr;
    do @(posedge clk); while (!sample_ready);
    if (track_sample(id, st, fr, ev)) begin
      pending_intervals = {pending_intervals, ev};
    end
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted interval, then let the pipe settle.
  task automatic drain_events(input int settle);
    sample_valid <= 1'b0;
    @(negedge clk);
    while (pending_intervals.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      pist_pkg::REG_USE_ALL_FRAMES: all_frames_r = data[0];
      pist_pkg::REG_WINDOW_FIRST:   first_r      = data[FRAME_W-1:0];
      pist_pkg::REG_WINDOW_LAST:    last_r       = data[FRAME_W-1:0];
      pist_pkg::REG_FRAME_COUNT:    num_frames_r = data[FRAME_W:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_window(input bit all, input int first, input int last,
                            input int count);
    drain_events(4);
    write_reg(pist_pkg::REG_USE_ALL_FRAMES, CFG_DATA_W'(all));
    write_reg(pist_pkg::REG_WINDOW_FIRST, CFG_DATA_W'(first));
    write_reg(pist_pkg::REG_WINDOW_LAST, CFG_DATA_W'(last));
    write_reg(pist_pkg::REG_FRAME_COUNT, CFG_DATA_W'(count));
  endtask

  // Reset window is frames 0 .. 0, so everything is dropped.
  task automatic test_reset_window();
    send_sample(16'd5, pist_pkg::STATE_LOW, 16'd0);
    send_sample(16'd5, pist_pkg::STATE_HIGH, 16'd0);
  endtask

  task automatic test_transitions();
    set_window(1'b1, 0, 0, 65536);
    send_sample(16'hFFFF, pist_pkg::STATE_HIGH, 16'd0);   // unseen id on high: dropped
    send_sample(16'hFFFF, pist_pkg::STATE_LOW, 16'd0);
    send_sample(16'hFFFF, pist_pkg::STATE_HIGH, 16'd1);
    send_sample(16'hFFFF, pist_pkg::STATE_HIGH, 16'd2);   // high over high: no change
    send_sample(16'hFFFF, 8'hFF, 16'd3);
    send_sample(16'hFFFF, 8'd2, 16'd3);
    send_sample(16'hFFFF, pist_pkg::STATE_LOW, 16'hFFFF);
    // same id back to back exercises the bypass
    send_sample(16'd0, pist_pkg::STATE_LOW, 16'h8000);
    send_sample(16'd0, pist_pkg::STATE_HIGH, 16'h8000);
    send_sample(16'd0, pist_pkg::STATE_LOW, 16'h8001);
    send_sample(16'd0, pist_pkg::STATE_LOW, 16'h8002);
  endtask

  task automatic test_window_edges();
    // first above last swaps; last clamps to count-1: window 10 .. 29
    set_window(1'b0, 40, 10, 30);
    send_sample(16'd7, pist_pkg::STATE_LOW, 16'd9);
    send_sample(16'd7, pist_pkg::STATE_LOW, 16'd10);
    send_sample(16'd7, pist_pkg::STATE_HIGH, 16'd29);
    send_sample(16'd7, pist_pkg::STATE_LOW, 16'd30);
    // both clamp: window 3 .. 4
    set_window(1'b0, 65535, 65535, 5);
    send_sample(16'd7, pist_pkg::STATE_LOW, 16'd4);
    // first and last zero: empty window
    set_window(1'b0, 0, 0, 65536);
    send_sample(16'd7, pist_pkg::STATE_HIGH, 16'd0);
    // zero count with all frames covers every frame
    set_window(1'b1, 0, 0, 0);
    send_sample(16'd7, pist_pkg::STATE_HIGH, 16'hFFFF);
    // count of two gives 0 .. 1
    set_window(1'b0, 500, 600, 2);
    send_sample(16'd7, pist_pkg::STATE_LOW, 16'd1);
    // count of one without all frames: empty window
    set_window(1'b0, 0, 1, 1);
    send_sample(16'd7, pist_pkg::STATE_HIGH, 16'd0);
  endtask

  task automatic test_random_streams();
    logic [ID_W-1:0]  pool [8];
    logic [FRAME_W:0] lo, hi;
    logic [STATE_W-1:0] st;
    int phase, n, items, span, hi_c, fr, pick;
    phase = 0;
    while (phase < 12) begin
      case (phase % 8)
        0: set_window(1'b1, $urandom_range(0, 65535), $urandom_range(0, 65535), 65536);
        1: set_window(1'b1, $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
        2: set_window(1'b0, 65535, 0, 65536);
        3: set_window(1'b0, $urandom_range(0, 65535), $urandom_range(0, 65535), 2);
        4: set_window($urandom_range(0, 1) == 1, 0, $urandom_range(0, 65535),
                      $urandom_range(0, 1));
        default: set_window($urandom_range(0, 1) == 1,
                            $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 45),
                            $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 45),
                            $urandom_range(0, 1) ? $urandom_range(0, 65536)
                                                 : $urandom_range(0, 40));
      endcase
      sender_fast   = ($urandom_range(0, 3) == 0);
      receiver_fast = ($urandom_range(0, 3) == 0);
      pool[0] = '0;
      pool[1] = '1;
      for (n = 2; n < 8; n++) pool[n] = ID_W'($urandom_range(0, 65535));
      window_of(lo, hi);
      hi_c = (hi > 17'hFFFF) ? 65535 : int'(hi);
      span = hi_c - int'(lo);
      fr = (span > 400) ? int'(lo) + $urandom_range(0, span - 300) : int'(lo);
      fr = (fr >= 3) ? fr - 3 : 0;
      items = (phase % 8 == 4) ? 20 : 160;
      for (n = 0; n < items; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) st = pist_pkg::STATE_LOW;
        else if (pick < 18) st = pist_pkg::STATE_HIGH;
        else st = STATE_W'($urandom_range(0, 255));
        send_sample(pool[$urandom_range(0, 7)], st, fr[FRAME_W-1:0]);
        fr = fr + $urandom_range(0, 2);
        if (fr > 65535) fr = 65535;
        // in even phases, hold off mid-phase until every interval is out
        if (n == items / 2 && phase % 2 == 0) drain_events(0);
      end
      phase++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && event_valid && event_ready) begin
      if (pending_intervals.size() == 0) begin
        $error("unexpected event transaction: id %0h start %0h end %0h",
               event_id, start_frame, end_frame);
        fail_count++;
      end else begin
        want = pending_intervals.pop_front();
        if (event_id !== want.id) begin
          $error("event_id: expected %0h, got %0h", want.id, event_id);
          fail_count++;
        end
        if (start_frame !== want.rise_frame) begin
          $error("start_frame: expected %0h, got %0h", want.rise_frame, start_frame);
          fail_count++;
        end
        if (end_frame !== want.fall_frame) begin
          $error("end_frame: expected %0h, got %0h", want.fall_frame, end_frame);
          fail_count++;
        end
      end
      recv_wait = receiver_fast ? 0 : $urandom_range(0, 6);
    end
  end

  // stall the event channel for the drawn number of cycles after each transaction
  always @(negedge clk) begin
    if (recv_wait > 0) begin
      event_ready <= 1'b0;
      recv_wait--;
    end else begin
      event_ready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int waited;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_reset_window();
    test_transitions();
    test_window_edges();
    test_random_streams();
    sample_valid <= 1'b0;
    waited = 0;
    while (pending_intervals.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (pending_intervals.size() != 0) begin
      $error("%0d predicted intervals never arrived", pending_intervals.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
